// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/slpq_pkg.sv =====
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared constants and types of the six-level priority queue.
// ----------------------------------------------------------------------------
package slpq_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int LEVELS_DEF      = 6;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADLEVEL = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

// ===== rtl/slpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// slpq_ctrl
// Sequencer: accepts a beat, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module slpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_strobe,
  output slpq_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_EXEC);
    end
  end

  assign busy       = (state_r == S_EXEC);
  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.exec   = (state_r == S_EXEC);
  assign out_strobe = strobe_r;

endmodule

// ===== rtl/slpq_dpath.sv =====
// ----------------------------------------------------------------------------
// slpq_dpath
// Entry pool, per-level linked lists, free list and result registers.
// ----------------------------------------------------------------------------
module slpq_dpath #(
  parameter int CAPACITY    = slpq_pkg::CAPACITY_DEF,
  parameter int LEVELS      = slpq_pkg::LEVELS_DEF,
  parameter int VALUE_WIDTH = slpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slpq_pkg::ctl_cmd_t  cmd,
  input  logic                in_operation,
  input  logic signed [31:0]  in_value_in,
  input  logic [2:0]          in_level_in,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_value_out,
  output logic [2:0]          out_level_out
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = $clog2(LEVELS);
  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0] vmem [CAPACITY];
  logic [AW-1:0] lmem [CAPACITY];

  logic [AW-1:0] head_r [LEVELS];
  logic [AW-1:0] tail_r [LEVELS];
  logic [CW-1:0] cnt_r  [LEVELS];
  logic [AW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] never_used_r, never_used_nxt;
  logic [CW-1:0] total_r, total_nxt;

  logic          op_r;
  logic [VW-1:0] val_r;
  logic [2:0]    lvl_r;
  logic [LW-1:0] sel_r;
  logic          found_r;
  logic [VW-1:0] vrd_r;
  logic [AW-1:0] lrd_r;

  logic [1:0]    status_r;
  logic [31:0]   value_r;
  logic [2:0]    level_r;

  logic          found;
  logic [LW-1:0] top;
  logic [AW-1:0] rd_addr;
  logic [VW+31:0] vin_ext;
  logic [VW+31:0] vout_ext;
  logic [LW+2:0]  lout_ext;

  logic          bad, full, reuse, enq_ok, deq_ok;
  logic [LW-1:0] li;
  logic [AW-1:0] slot;
  logic          lmem_we;
  logic [AW-1:0] lmem_wa, lmem_wd;
  logic [1:0]    status_nxt;

  always_comb begin
    found = 1'b0;
    top   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        found = 1'b1;
        top   = LW'(i);
      end
    end
  end

  assign rd_addr  = (in_operation == slpq_pkg::OP_DEQ) ? head_r[top] : free_head_r;
  assign vin_ext  = {{VW{1'b0}}, in_value_in};
  assign vout_ext = {32'b0, vrd_r};
  assign lout_ext = {3'b0, sel_r};

  always_comb begin
    bad    = 32'(lvl_r) >= LEVELS;
    full   = (total_r == CW'(CAPACITY));
    reuse  = (never_used_r == CW'(CAPACITY));
    li     = LW'(lvl_r);
    slot   = reuse ? free_head_r : never_used_r[AW-1:0];
    enq_ok = cmd.exec && (op_r == slpq_pkg::OP_ENQ) && !bad && !full;
    deq_ok = cmd.exec && (op_r == slpq_pkg::OP_DEQ) && found_r;

    if (op_r == slpq_pkg::OP_ENQ) begin
      status_nxt = bad ? slpq_pkg::ST_BADLEVEL :
                   full ? slpq_pkg::ST_FULL : slpq_pkg::ST_OK;
    end else begin
      status_nxt = found_r ? slpq_pkg::ST_OK : slpq_pkg::ST_EMPTY;
    end

    lmem_we = deq_ok || (enq_ok && (cnt_r[li] != '0));
    lmem_wa = deq_ok ? head_r[sel_r] : tail_r[li];
    lmem_wd = deq_ok ? free_head_r : slot;

    free_head_nxt  = free_head_r;
    never_used_nxt = never_used_r;
    total_nxt      = total_r;
    if (enq_ok) begin
      total_nxt = total_r + CW'(1);
      if (reuse) free_head_nxt = lrd_r;
      else never_used_nxt = never_used_r + CW'(1);
    end else if (deq_ok) begin
      total_nxt     = total_r - CW'(1);
      free_head_nxt = head_r[sel_r];
    end
  end

  // pool memories: read on accept, write in execute
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vrd_r <= vmem[rd_addr];
      lrd_r <= lmem[rd_addr];
    end
    if (enq_ok) vmem[slot] <= val_r;
    if (lmem_we) lmem[lmem_wa] <= lmem_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      val_r   <= vin_ext[VW-1:0];
      lvl_r   <= in_level_in;
      sel_r   <= top;
      found_r <= found;
    end
    if (enq_ok) begin
      tail_r[li] <= slot;
      if (cnt_r[li] == '0) head_r[li] <= slot;
    end
    if (deq_ok) head_r[sel_r] <= lrd_r;
    if (cmd.exec) begin
      status_r <= status_nxt;
      value_r  <= deq_ok ? vout_ext[31:0] : 32'b0;
      level_r  <= deq_ok ? lout_ext[2:0] : 3'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) cnt_r[i] <= '0;
      free_head_r  <= '0;
      never_used_r <= '0;
      total_r      <= '0;
    end else begin
      if (enq_ok) cnt_r[li] <= cnt_r[li] + CW'(1);
      if (deq_ok) cnt_r[sel_r] <= cnt_r[sel_r] - CW'(1);
      free_head_r  <= free_head_nxt;
      never_used_r <= never_used_nxt;
      total_r      <= total_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_value_out = value_r;
  assign out_level_out = level_r;

endmodule

// ===== rtl/six_level_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// six_level_priority_queue_top
// Bounded priority queue over a shared entry pool with per-level linked lists.
// An accepted beat passes through the execute state and then the strobe register.
// A new beat is not accepted while busy; busy covers the execute cycle in which
// the pool memories, read at accept, are written back.
// Reset clears counts and free list at once; no clearing pass. Results are
// strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module six_level_priority_queue_top #(
  parameter int CAPACITY    = slpq_pkg::CAPACITY_DEF,
  parameter int LEVELS      = slpq_pkg::LEVELS_DEF,
  parameter int VALUE_WIDTH = slpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic signed [31:0] in_value_in,
  input  logic [2:0]         in_level_in,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_out,
  output logic [2:0]         out_level_out
);

  slpq_pkg::ctl_cmd_t cmd;

  slpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  slpq_dpath #(
    .CAPACITY    (CAPACITY),
    .LEVELS      (LEVELS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_value_in   (in_value_in),
    .in_level_in   (in_level_in),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_level_out (out_level_out)
  );

endmodule

// ===== rtl/slpq_checker.sv =====
// ----------------------------------------------------------------------------
// slpq_checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slpq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [1:0]        out_status,
  input logic signed [31:0] out_value_out,
  input logic [2:0]        out_level_out
);

  logic fail_beat;
  logic fields_zero;

  assign fail_beat   = out_strobe && (out_status != slpq_pkg::ST_OK);
  assign fields_zero = (out_value_out == 32'sd0) && (out_level_out == 3'd0);

  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `CHK_NEXT(a_one_exec, clk, rst_n, busy, !busy)
  `CHK_NEXT(a_exec_strobe, clk, rst_n, busy, out_strobe)
  `CHK_SAME(a_strobe_after_exec, clk, rst_n, out_strobe, $past(busy))
  `CHK_SAME(a_fail_zero, clk, rst_n, fail_beat, fields_zero)

endmodule

bind six_level_priority_queue_top slpq_checker u_slpq_checker (.*);
